// ----- sv/alrf_pkg.sv -----
// shared constants and helpers for the addressed level frame receiver
// no dependencies

package alrf_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned ADDR_W  = 7;
	localparam int unsigned POS_W   = 4;
	localparam int unsigned CHAN_N  = 4;

	localparam logic [BYTE_W-1:0] START_BYTE     = 8'd253;
	localparam logic [BYTE_W-1:0] ADDR_BYTE      = 8'd250;
	localparam logic [BYTE_W-1:0] BROADCAST_BYTE = 8'd251;
	localparam logic [BYTE_W-1:0] CHK_RESET      = 8'd255;
	localparam logic [BYTE_W-1:0] LEVEL_RESET    = 8'd5;
	localparam logic [POS_W-1:0]  FRAME_BYTES    = 4'd6;
	localparam logic [POS_W-1:0]  POS_ADDR       = 4'd0;
	localparam logic [POS_W-1:0]  POS_FIRST_LVL  = 4'd1;
	localparam logic [POS_W-1:0]  POS_LAST_LVL   = 4'd4;

	typedef logic [BYTE_W-1:0] byte_t;

	// rotate left by three
	function automatic byte_t rotl3(input byte_t v);
		return {v[BYTE_W-4:0], v[BYTE_W-1:BYTE_W-3]};
	endfunction

endpackage

// ----- sv/addressed_level_frame_receiver.sv -----
// addressed level frame receiver: frame parse, checksum, channel level registers
// depends on alrf_pkg
// result word is registered: valid in the cycle after the input word is accepted
// throughput: one word per cycle while out_ready is high; the single result register frees when out_ready is high
// all per-byte work is one compare/xor pass ahead of the state and result registers
// reset: no frame open, checksum 0, last checksum 255, address 0, all levels 5

module addressed_level_frame_receiver (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	input  logic       framing_error,
	input  logic [6:0] switch_address,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] channel_level_a,
	output logic [7:0] channel_level_b,
	output logic [7:0] channel_level_c,
	output logic [7:0] channel_level_d,
	output logic       levels_updated
);

	logic                      frame_open_q;
	logic [alrf_pkg::POS_W-1:0] frame_pos_q;
	alrf_pkg::byte_t           run_chk_q;
	alrf_pkg::byte_t           last_chk_q;
	alrf_pkg::byte_t           store_q [alrf_pkg::CHAN_N];
	logic [alrf_pkg::ADDR_W-1:0] dev_addr_q;
	alrf_pkg::byte_t           level_q [alrf_pkg::CHAN_N];
	logic                      out_valid_q;
	logic                      updated_q;

	logic                      accept;
	logic                      open_in;
	logic                      is_start;
	logic                      is_addr;
	logic                      is_chk;
	logic                      addr_ok;
	logic                      take_byte;
	logic                      chk_match;
	logic                      open_d;
	logic [alrf_pkg::POS_W-1:0] pos_d;
	alrf_pkg::byte_t           chk_d;
	logic                      upd_d;
	logic [1:0]                store_idx;

	// handshake: result slot frees when taken
	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	// byte classification
	assign open_in   = frame_open_q && !framing_error;
	assign is_start  = (rx_byte == alrf_pkg::START_BYTE);
	assign is_addr   = (rx_byte == alrf_pkg::ADDR_BYTE);
	assign is_chk    = !is_start && !is_addr && open_in && (frame_pos_q >= alrf_pkg::FRAME_BYTES);
	assign addr_ok   = (rx_byte == {1'b0, dev_addr_q}) || (rx_byte == alrf_pkg::BROADCAST_BYTE);
	assign take_byte = !is_start && !is_addr && open_in && !is_chk
		&& ((frame_pos_q != alrf_pkg::POS_ADDR) || addr_ok);
	assign chk_match = is_chk && (rx_byte == run_chk_q) && (run_chk_q != last_chk_q);
	assign store_idx = 2'(frame_pos_q - alrf_pkg::POS_FIRST_LVL);

	// next frame state
	always_comb begin
		open_d = open_in;
		pos_d  = frame_pos_q;
		chk_d  = run_chk_q;
		upd_d  = chk_match;
		if (is_start) begin
			open_d = 1'b1;
			pos_d  = '0;
			chk_d  = '0;
		end else if (is_addr) begin
			open_d = open_in;
		end else if (is_chk) begin
			open_d = 1'b0;
		end else if (open_in) begin
			if (take_byte) begin
				chk_d = alrf_pkg::rotl3(run_chk_q) ^ rx_byte;
				pos_d = frame_pos_q + 1'b1;
			end else begin
				open_d = 1'b0;
			end
		end
	end

	// control and level registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_open_q <= 1'b0;
			frame_pos_q  <= '0;
			run_chk_q    <= '0;
			last_chk_q   <= alrf_pkg::CHK_RESET;
			dev_addr_q   <= '0;
			out_valid_q  <= 1'b0;
			updated_q    <= 1'b0;
			for (int i = 0; i < alrf_pkg::CHAN_N; i++) begin
				level_q[i] <= alrf_pkg::LEVEL_RESET;
			end
		end else begin
			if (accept) begin
				frame_open_q <= open_d;
				frame_pos_q  <= pos_d;
				run_chk_q    <= chk_d;
				updated_q    <= upd_d;
				if (is_addr) begin
					dev_addr_q <= switch_address;
				end
				if (chk_match) begin
					last_chk_q <= run_chk_q;
					for (int i = 0; i < alrf_pkg::CHAN_N; i++) begin
						level_q[i] <= store_q[i];
					end
				end
			end
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
				updated_q   <= 1'b0;
			end
		end
	end

	// frame byte store, no reset
	always_ff @(posedge clk) begin
		if (accept && take_byte && (frame_pos_q >= alrf_pkg::POS_FIRST_LVL)
			&& (frame_pos_q <= alrf_pkg::POS_LAST_LVL)) begin
			store_q[store_idx] <= rx_byte;
		end
	end

	assign out_valid       = out_valid_q;
	assign channel_level_a = level_q[0];
	assign channel_level_b = level_q[1];
	assign channel_level_c = level_q[2];
	assign channel_level_d = level_q[3];
	assign levels_updated  = updated_q;

`ifndef SYNTHESIS
	// start byte opens a fresh frame
	a_start_opens: assert property (@(posedge clk) disable iff (!arst_n)
		accept && is_start |=> frame_open_q && (frame_pos_q == '0) && (run_chk_q == '0))
		else $error("start byte did not open a clean frame");

	// position never runs past the checksum byte
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		frame_open_q |-> (frame_pos_q <= alrf_pkg::FRAME_BYTES))
		else $error("frame position out of range");

	// accepted frame records its checksum
	a_last_chk: assert property (@(posedge clk) disable iff (!arst_n)
		accept && chk_match |=> (last_chk_q == $past(run_chk_q)) && updated_q)
		else $error("accepted checksum not recorded");

	// stray bytes never open a frame
	a_closed_stays: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !frame_open_q && !is_start |=> !frame_open_q)
		else $error("frame opened without start byte");

	// update flag only with a new result word
	a_upd_valid: assert property (@(posedge clk) disable iff (!arst_n)
		updated_q |-> out_valid_q)
		else $error("update flag without valid result");
`endif

endmodule

// ----- tb/tb_addressed_level_frame_receiver.sv -----
// self-checking testbench for addressed_level_frame_receiver: framed byte stream in, levels out
// depends on alrf_pkg and addressed_level_frame_receiver
`timescale 1ns / 100ps

typedef struct packed {
	alrf_pkg::byte_t a;
	alrf_pkg::byte_t b;
	alrf_pkg::byte_t c;
	alrf_pkg::byte_t d;
	logic            updated;
} level_word_t;

// tracks the receiver state and holds the level words still owed by the block
class level_scoreboard;
	bit              frame_open;
	logic [3:0]      frame_pos;
	alrf_pkg::byte_t run_sum;
	alrf_pkg::byte_t last_sum;
	alrf_pkg::byte_t store[4];
	logic [6:0]      dev_addr;
	alrf_pkg::byte_t lvl[4];
	level_word_t     owed_q[$];
	int              errors;

	function new();
		frame_open = 1'b0;
		frame_pos  = alrf_pkg::POS_ADDR;
		run_sum    = 8'd0;
		last_sum   = alrf_pkg::CHK_RESET;
		dev_addr   = 7'd0;
		errors     = 0;
		for (int i = 0; i < 4; i++) begin
			store[i] = 8'd0;
			lvl[i]   = alrf_pkg::LEVEL_RESET;
		end
	endfunction

	// advance the frame parser by one accepted word and queue the level word it yields
	function void note_input(alrf_pkg::byte_t rx, bit ferr, logic [6:0] sw);
		level_word_t w;
		bit          upd;
		upd = 1'b0;
		if (ferr)
			frame_open = 1'b0;
		if (rx == alrf_pkg::START_BYTE) begin
			frame_open = 1'b1;
			frame_pos  = alrf_pkg::POS_ADDR;
			run_sum    = 8'd0;
		end else if (rx == alrf_pkg::ADDR_BYTE) begin
			dev_addr = sw;
		end else if (frame_open && frame_pos >= alrf_pkg::FRAME_BYTES) begin
			// checksum byte: load levels only on a fresh match
			if (rx == run_sum && run_sum != last_sum) begin
				lvl      = store;
				last_sum = run_sum;
				upd      = 1'b1;
			end
			frame_open = 1'b0;
		end else if (frame_open) begin
			if (frame_pos == alrf_pkg::POS_ADDR && rx != {1'b0, dev_addr}
					&& rx != alrf_pkg::BROADCAST_BYTE) begin
				frame_open = 1'b0;
			end else begin
				if (frame_pos >= alrf_pkg::POS_FIRST_LVL && frame_pos <= alrf_pkg::POS_LAST_LVL)
					store[2'(frame_pos - alrf_pkg::POS_FIRST_LVL)] = rx;
				run_sum   = {run_sum[4:0], run_sum[7:5]} ^ rx;
				frame_pos = frame_pos + 4'd1;
			end
		end
		w = '{lvl[0], lvl[1], lvl[2], lvl[3], upd};
		owed_q.push_back(w);
	endfunction

	// compare one accepted level word with the oldest one owed
	function void check_result(level_word_t got);
		level_word_t want;
		if (owed_q.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("unexpected level word a=%0d b=%0d c=%0d d=%0d upd=%0d",
					got.a, got.b, got.c, got.d, got.updated);
			return;
		end
		want = owed_q.pop_front();
		if (got.a !== want.a || got.b !== want.b || got.c !== want.c ||
				got.d !== want.d || got.updated !== want.updated) begin
			errors++;
			if (errors <= 10)
				$display({"level word mismatch at %0t: want a=%0d b=%0d c=%0d d=%0d upd=%0d,",
					" got a=%0d b=%0d c=%0d d=%0d upd=%0d"},
					$realtime, want.a, want.b, want.c, want.d, want.updated,
					got.a, got.b, got.c, got.d, got.updated);
		end
	endfunction

	function int outstanding();
		return owed_q.size();
	endfunction
endclass

module tb_addressed_level_frame_receiver;

	localparam int CYCLE_LIMIT = 500000;
	localparam int FRAME_WORD_TARGET = 1500;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] rx_byte = 8'd0;
	logic       framing_error = 1'b0;
	logic [6:0] switch_address = 7'd0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] channel_level_a;
	logic [7:0] channel_level_b;
	logic [7:0] channel_level_c;
	logic [7:0] channel_level_d;
	logic       levels_updated;

	level_scoreboard sb = new();

	int              cycle_count = 0;
	int              frame_words = 0;
	bit              in_quiet = 1'b0;
	bit              out_quiet = 1'b0;
	int              out_stall;
	bit              have_prev = 1'b0;
	alrf_pkg::byte_t prev_body[6];

	addressed_level_frame_receiver u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.rx_byte         (rx_byte),
		.framing_error   (framing_error),
		.switch_address  (switch_address),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.channel_level_a (channel_level_a),
		.channel_level_b (channel_level_b),
		.channel_level_c (channel_level_c),
		.channel_level_d (channel_level_d),
		.levels_updated  (levels_updated)
	);

	// clock
	initial begin
		forever #1 clk = ~clk;
	end

	// watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT)
			@(posedge clk) cycle_count++;
		$display("addressed_level_frame_receiver regression: fail");
		$finish;
	end

	// running checksum over the six frame bytes
	function automatic alrf_pkg::byte_t frame_sum(input alrf_pkg::byte_t body[6]);
		alrf_pkg::byte_t s;
		s = 8'd0;
		for (int i = 0; i < 6; i++)
			s = {s[4:0], s[7:5]} ^ body[i];
		return s;
	endfunction

	// level byte, mostly steering clear of the start and address codes
	function automatic alrf_pkg::byte_t level_pick();
		alrf_pkg::byte_t v;
		v = alrf_pkg::byte_t'($urandom_range(0, 255));
		if ((v == alrf_pkg::START_BYTE || v == alrf_pkg::ADDR_BYTE)
				&& $urandom_range(0, 9) != 0)
			v = v ^ 8'd1;
		return v;
	endfunction

	function automatic logic [6:0] rand_sw();
		return 7'($urandom_range(0, 127));
	endfunction

	// send one word: optional idle gap, then hold valid until accepted
	task automatic send_word(input alrf_pkg::byte_t rx, input bit ferr, input logic [6:0] sw);
		int gap;
		gap = in_quiet ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid       <= 1'b1;
		rx_byte        <= rx;
		framing_error  <= ferr;
		switch_address <= sw;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_input(rx, ferr, sw);
	endtask

	// one frame with random content, sometimes broken or a repeat of the last one
	task automatic send_frame();
		alrf_pkg::byte_t body[6];
		alrf_pkg::byte_t chk;
		int              r;
		int              addr_at;
		int              ferr_at;
		int              cut_at;
		if (have_prev && $urandom_range(0, 99) < 15) begin
			body = prev_body;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 60)
				body[0] = {1'b0, sb.dev_addr};
			else if (r < 90)
				body[0] = alrf_pkg::BROADCAST_BYTE;
			else
				body[0] = alrf_pkg::byte_t'($urandom_range(0, 255));
			for (int i = 1; i < 6; i++)
				body[i] = level_pick();
		end
		chk = frame_sum(body);
		if ($urandom_range(0, 99) < 15)
			chk = alrf_pkg::byte_t'($urandom_range(0, 255));
		prev_body = body;
		have_prev = 1'b1;
		in_quiet = ($urandom_range(0, 3) == 0);
		addr_at = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 7) : -1;
		ferr_at = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 7) : -1;
		cut_at  = ($urandom_range(0, 24) == 0) ? $urandom_range(1, 7) : -1;
		send_word(alrf_pkg::START_BYTE, ferr_at == 0, rand_sw());
		for (int i = 0; i < 7; i++) begin
			if (addr_at == i + 1)
				send_word(alrf_pkg::ADDR_BYTE, 1'b0, rand_sw());
			if (cut_at == i + 1)
				send_word(alrf_pkg::START_BYTE, 1'b0, rand_sw());
			send_word((i < 6) ? body[i] : chk, ferr_at == i + 1, rand_sw());
		end
		frame_words += 8;
	endtask

	// directed words: extremes, address latch, drops, restart, repeated checksum
	task automatic run_directed();
		alrf_pkg::byte_t body[6];
		alrf_pkg::byte_t chk;
		body = '{alrf_pkg::BROADCAST_BYTE, 8'd255, 8'd0, 8'd170, 8'd85, 8'd1};
		chk  = frame_sum(body);
		in_quiet = 1'b0;
		send_word(8'd0, 1'b0, 7'd0);
		send_word(alrf_pkg::ADDR_BYTE, 1'b1, 7'h7f);
		// broadcast frame with an address latch in the middle
		send_word(alrf_pkg::START_BYTE, 1'b0, 7'd0);
		for (int i = 0; i < 6; i++) begin
			if (i == 3)
				send_word(alrf_pkg::ADDR_BYTE, 1'b0, 7'h7f);
			send_word(body[i], 1'b0, 7'd0);
		end
		send_word(chk, 1'b0, 7'd0);
		// restart with bad stop, then a wrong address
		send_word(alrf_pkg::START_BYTE, 1'b0, 7'd0);
		send_word(alrf_pkg::START_BYTE, 1'b1, 7'h7f);
		send_word(8'h80, 1'b0, 7'd0);
		// framing error on the address byte drops the frame
		send_word(alrf_pkg::START_BYTE, 1'b0, 7'd0);
		send_word(8'd127, 1'b1, 7'd0);
		// same frame again: checksum repeats, no update
		send_word(alrf_pkg::START_BYTE, 1'b0, 7'h7f);
		for (int i = 0; i < 6; i++)
			send_word(body[i], 1'b0, 7'h7f);
		send_word(chk, 1'b0, 7'h7f);
	endtask

	// mostly well-formed frames, with address latches and noise between them
	task automatic run_random();
		int r;
		while (frame_words < FRAME_WORD_TARGET) begin
			r = $urandom_range(0, 99);
			if (r < 70) begin
				send_frame();
			end else if (r < 80) begin
				send_word(alrf_pkg::ADDR_BYTE, $urandom_range(0, 7) == 0, rand_sw());
			end else begin
				in_quiet = ($urandom_range(0, 3) == 0);
				send_word(alrf_pkg::byte_t'($urandom_range(0, 255)),
					$urandom_range(0, 7) == 0, rand_sw());
			end
		end
	endtask

	// result side: random stall before each word
	initial begin
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 29) == 0)
				out_quiet = !out_quiet;
			out_stall = out_quiet ? 0 : $urandom_range(0, 17);
			if (out_stall > 0) begin
				out_ready <= 1'b0;
				repeat (out_stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result('{channel_level_a, channel_level_b, channel_level_c,
				channel_level_d, levels_updated});
	end

	// reset, stimulus, drain, verdict
	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		run_random();
		in_valid <= 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.outstanding() != 0)
			sb.errors++;
		if (sb.errors == 0)
			$display("addressed_level_frame_receiver regression: pass");
		else
			$display("addressed_level_frame_receiver regression: fail");
		$finish;
	end

endmodule
